### rtl/tbsc_pkg.sv
// shared constants, control word and status types for the touch baseline step counter
`default_nettype none

package tbsc_pkg;

    // calibration window: a power of two so the mean and variance scale by shifts
    localparam int CAL_LOG2    = 9;
    localparam int CAL_SAMPLES = 1 << CAL_LOG2;

    // field widths
    localparam int SMP_W = 16;
    localparam int CNT_W = 8;

    // accumulator and datapath widths
    localparam int IDX_W     = CAL_LOG2 + 1;
    localparam int SUM_W     = SMP_W + CAL_LOG2;
    localparam int QSUM_W    = 2 * SMP_W + CAL_LOG2;
    localparam int DIFF_W    = 2 * SUM_W;
    localparam int RAD_SHIFT = 2 * CAL_LOG2 - 8;
    localparam int RAD_W     = DIFF_W - RAD_SHIFT;
    localparam int SQRT_W    = RAD_W / 2;
    localparam int ITER_W    = $clog2(SQRT_W);

    // microprogram counter width
    localparam int PC_W = 4;

    // datapath operation selected by each control word
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SQUARE,
        DP_ACCUM,
        DP_SUMSQ,
        DP_DIFF,
        DP_SQRT_STEP,
        DP_FINISH,
        DP_COUNT,
        DP_OUTPUT
    } tbsc_dp_op_t;

    // jump condition: taken goes to target, otherwise to the next word
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_COUNT_OP,
        C_NOT_FULL,
        C_ITER_MORE,
        C_OUT_BUSY
    } tbsc_cond_t;

    // one word of the control store
    typedef struct packed {
        tbsc_dp_op_t     op;
        tbsc_cond_t      cond;
        logic [PC_W-1:0] target;
        logic            in_ready;
    } tbsc_ctrl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic req;
        logic count_op;
        logic idx_full;
        logic iter_more;
        logic out_busy;
    } tbsc_status_t;

endpackage

`default_nettype wire

### rtl/touch_baseline_step_counter.sv
// Touch baseline step counter: calibration statistics and person counting.
// Steps: count request: wait, branch, count, output. Calibration request: wait,
// branch, square, accumulate, output; the request that completes the window runs
// sum-square, difference, the 20-step square root and finish before output.
// Requests are taken only in the wait step; the output step holds while stalled.
// Reset: asynchronous active low; count 0, baseline 65535, threshold 0, not calibrated.
`default_nettype none

module touch_baseline_step_counter (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          operation,
    input  wire [tbsc_pkg::SMP_W-1:0]    sample,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [tbsc_pkg::CNT_W-1:0]   person_count,
    output logic                         calibrated,
    output logic [tbsc_pkg::SMP_W-1:0]   baseline,
    output logic [tbsc_pkg::SMP_W-1:0]   noise_threshold
);
    import tbsc_pkg::*;

    tbsc_ctrl_t   ctrl;
    tbsc_status_t status;

    // architectural state
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic [SMP_W-1:0]  last_reg,       last_next;
    logic              last_valid_reg, last_valid_next;
    logic [SMP_W-1:0]  baseline_reg,   baseline_next;
    logic [SMP_W-1:0]  threshold_reg,  threshold_next;
    logic [SUM_W-1:0]  sum_reg,        sum_next;
    logic [QSUM_W-1:0] qsum_reg,       qsum_next;
    logic [IDX_W-1:0]  idx_reg,        idx_next;
    logic              cal_done_reg,   cal_done_next;
    logic              out_valid_reg,  out_valid_next;

    // working registers
    logic              op_reg,         op_next;
    logic [SMP_W-1:0]  smp_reg,        smp_next;
    logic [DIFF_W-1:0] prod_reg,       prod_next;
    logic [RAD_W-1:0]  rem_reg,        rem_next;
    logic [RAD_W-1:0]  res_reg,        res_next;
    logic [RAD_W-1:0]  bit_reg,        bit_next;
    logic [ITER_W-1:0] iter_reg,       iter_next;

    // result register
    logic [CNT_W-1:0]  out_count_reg,  out_count_next;
    logic              out_cal_reg,    out_cal_next;
    logic [SMP_W-1:0]  out_base_reg,   out_base_next;
    logic [SMP_W-1:0]  out_thr_reg,    out_thr_next;

    // arithmetic
    logic [2*SMP_W-1:0]  smp_sq;
    logic [DIFF_W-1:0]   sum_sq;
    logic [DIFF_W-1:0]   nq;
    logic [DIFF_W-1:0]   diff;
    logic [SUM_W+1:0]    base_sum;
    logic [SMP_W:0]      base_q;
    logic [RAD_W-1:0]    trial;
    logic [SQRT_W+1:0]   thr3;
    logic [SQRT_W-4:0]   thr_q;
    logic [SMP_W:0]      x_ext;
    logic [SMP_W:0]      x_plus_th;
    logic [SMP_W:0]      last_plus_th;
    logic                near_base;
    logic                rise;
    logic                drop;
    logic                out_busy;

    // sequencer
    tbsc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // flags for the jump conditions
    assign out_busy = out_valid_reg && out_stall;
    always_comb
    begin
        status.req       = in_valid;
        status.count_op  = op_reg;
        status.idx_full  = (idx_reg == IDX_W'(CAL_SAMPLES));
        status.iter_more = (iter_reg != '0);
        status.out_busy  = out_busy;
    end

    // multipliers, both feed prod_reg
    assign smp_sq = (2*SMP_W)'(smp_reg) * (2*SMP_W)'(smp_reg);
    assign sum_sq = DIFF_W'(sum_reg) * DIFF_W'(sum_reg);

    // n*q - s*s clamped at zero, then scaled to 256 * variance
    assign nq   = {qsum_reg, {CAL_LOG2{1'b0}}};
    assign diff = (nq > prod_reg) ? (nq - prod_reg) : '0;

    // rounded mean
    assign base_sum = {1'b0, sum_reg, 1'b0} + (SUM_W+2)'(CAL_SAMPLES);
    assign base_q   = base_sum[SUM_W+1:CAL_LOG2+1];

    // one restoring square root step
    assign trial = res_reg + bit_reg;

    // ceil(3 * sigma_q4 / 32)
    assign thr3  = {1'b0, res_reg[SQRT_W-1:0], 1'b0} + (SQRT_W+2)'(res_reg[SQRT_W-1:0])
                 + (SQRT_W+2)'(31);
    assign thr_q = thr3[SQRT_W+1:5];

    // count comparisons without wrap
    assign x_ext        = {1'b0, smp_reg};
    assign x_plus_th    = x_ext + {1'b0, threshold_reg};
    assign last_plus_th = {1'b0, last_reg} + {1'b0, threshold_reg};
    assign near_base    = x_plus_th > {1'b0, baseline_reg};
    assign rise         = x_ext > last_plus_th;
    assign drop         = x_plus_th < {1'b0, last_reg};

    // datapath operation decode
    always_comb
    begin
        count_next      = count_reg;
        last_next       = last_reg;
        last_valid_next = last_valid_reg;
        baseline_next   = baseline_reg;
        threshold_next  = threshold_reg;
        sum_next        = sum_reg;
        qsum_next       = qsum_reg;
        idx_next        = idx_reg;
        cal_done_next   = cal_done_reg;
        out_valid_next  = out_valid_reg && out_stall;
        op_next         = op_reg;
        smp_next        = smp_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        bit_next        = bit_reg;
        iter_next       = iter_reg;
        out_count_next  = out_count_reg;
        out_cal_next    = out_cal_reg;
        out_base_next   = out_base_reg;
        out_thr_next    = out_thr_reg;

        unique case (ctrl.op)
            DP_NOP:
            begin
            end
            DP_CAPTURE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    smp_next = sample;
                end
            end
            DP_SQUARE:
            begin
                prod_next = DIFF_W'(smp_sq);
                sum_next  = sum_reg + SUM_W'(smp_reg);
                idx_next  = idx_reg + 1'b1;
            end
            DP_ACCUM:
            begin
                qsum_next = qsum_reg + QSUM_W'(prod_reg[2*SMP_W-1:0]);
            end
            DP_SUMSQ:
            begin
                prod_next = sum_sq;
            end
            DP_DIFF:
            begin
                rem_next      = diff[DIFF_W-1:RAD_SHIFT];
                res_next      = '0;
                bit_next      = RAD_W'(1) << (RAD_W - 2);
                iter_next     = ITER_W'(SQRT_W - 1);
                baseline_next = base_q[SMP_W] ? {SMP_W{1'b1}} : base_q[SMP_W-1:0];
            end
            DP_SQRT_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - 1'b1;
            end
            DP_FINISH:
            begin
                threshold_next  = (thr_q > (SQRT_W-3)'({SMP_W{1'b1}})) ? {SMP_W{1'b1}}
                                                                     : thr_q[SMP_W-1:0];
                sum_next        = '0;
                qsum_next       = '0;
                idx_next        = '0;
                cal_done_next   = 1'b1;
                last_valid_next = 1'b0;
            end
            DP_COUNT:
            begin
                if (!last_valid_reg)
                begin
                    last_valid_next = 1'b1;
                end
                else if (near_base)
                begin
                    count_next = '0;
                end
                else if (rise)
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                else if (drop)
                begin
                    if (count_reg != {CNT_W{1'b1}})
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                last_next = smp_reg;
            end
            DP_OUTPUT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_cal_next   = cal_done_reg;
                    out_base_next  = baseline_reg;
                    out_thr_next   = threshold_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            baseline_reg   <= {SMP_W{1'b1}};
            threshold_reg  <= '0;
            sum_reg        <= '0;
            qsum_reg       <= '0;
            idx_reg        <= '0;
            cal_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            last_reg       <= last_next;
            last_valid_reg <= last_valid_next;
            baseline_reg   <= baseline_next;
            threshold_reg  <= threshold_next;
            sum_reg        <= sum_next;
            qsum_reg       <= qsum_next;
            idx_reg        <= idx_next;
            cal_done_reg   <= cal_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        smp_reg       <= smp_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        iter_reg      <= iter_next;
        out_count_reg <= out_count_next;
        out_cal_reg   <= out_cal_next;
        out_base_reg  <= out_base_next;
        out_thr_reg   <= out_thr_next;
    end

    // ports
    assign in_stall        = !ctrl.in_ready;
    assign out_valid       = out_valid_reg;
    assign person_count    = out_count_reg;
    assign calibrated      = out_cal_reg;
    assign baseline        = out_base_reg;
    assign noise_threshold = out_thr_reg;

    // window index never passes the window size
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(CAL_SAMPLES))
        else $error("calibration index beyond window");

    // threshold moves only at the finishing step
    a_thr_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op != DP_FINISH |=> $stable(threshold_reg))
        else $error("threshold changed outside finishing step");

    // count moves only at the count step
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op != DP_COUNT |=> $stable(count_reg))
        else $error("count changed outside count step");

    // a new result appears only from the output step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == DP_OUTPUT))
        else $error("result raised outside output step");

endmodule

`default_nettype wire

### rtl/tbsc_seq.sv
// microprogram sequencer: step counter, control store and jump logic
`default_nettype none

module tbsc_seq (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tbsc_pkg::tbsc_status_t status,
    output tbsc_pkg::tbsc_ctrl_t   ctrl
);
    import tbsc_pkg::*;

    // step addresses
    localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_BRANCH = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SQUARE = PC_W'(2);
    localparam logic [PC_W-1:0] PC_ACCUM  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_SUMSQ  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_DIFF   = PC_W'(5);
    localparam logic [PC_W-1:0] PC_SQRT   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_FINISH = PC_W'(7);
    localparam logic [PC_W-1:0] PC_COUNT  = PC_W'(8);
    // last word of the store: its fall-through wraps to the wait step
    localparam logic [PC_W-1:0] PC_OUT    = PC_W'((1 << PC_W) - 1);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    // control store
    function automatic tbsc_ctrl_t ucode(input logic [PC_W-1:0] pc);
        tbsc_ctrl_t w;
        begin
            w = '{op: DP_NOP, cond: C_ALWAYS, target: PC_WAIT, in_ready: 1'b0};
            unique case (pc)
                PC_WAIT:   w = '{DP_CAPTURE,   C_NO_REQ,    PC_WAIT,   1'b1};
                PC_BRANCH: w = '{DP_NOP,       C_COUNT_OP,  PC_COUNT,  1'b0};
                PC_SQUARE: w = '{DP_SQUARE,    C_NEVER,     PC_WAIT,   1'b0};
                PC_ACCUM:  w = '{DP_ACCUM,     C_NOT_FULL,  PC_OUT,    1'b0};
                PC_SUMSQ:  w = '{DP_SUMSQ,     C_NEVER,     PC_WAIT,   1'b0};
                PC_DIFF:   w = '{DP_DIFF,      C_NEVER,     PC_WAIT,   1'b0};
                PC_SQRT:   w = '{DP_SQRT_STEP, C_ITER_MORE, PC_SQRT,   1'b0};
                PC_FINISH: w = '{DP_FINISH,    C_ALWAYS,    PC_OUT,    1'b0};
                PC_COUNT:  w = '{DP_COUNT,     C_ALWAYS,    PC_OUT,    1'b0};
                PC_OUT:    w = '{DP_OUTPUT,    C_OUT_BUSY,  PC_OUT,    1'b0};
                default:   w = '{DP_NOP,       C_ALWAYS,    PC_WAIT,   1'b0};
            endcase
            return w;
        end
    endfunction

    // fetch
    assign ctrl = ucode(pc_reg);

    // jump condition select
    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_REQ:    taken = !status.req;
            C_COUNT_OP:  taken = status.count_op;
            C_NOT_FULL:  taken = !status.idx_full;
            C_ITER_MORE: taken = status.iter_more;
            C_OUT_BUSY:  taken = status.out_busy;
            default:     taken = 1'b0;
        endcase
    end

    // next step address
    always_comb
    begin
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // the wait step is the only one that takes a request
    a_ready_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.in_ready |-> (pc_reg == PC_WAIT))
        else $error("ready outside the wait step");

    // the square root loop leaves only to the finishing step
    a_sqrt_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_SQRT) && !status.iter_more |=> (pc_reg == PC_FINISH))
        else $error("square root loop left to the wrong step");

    // the output step holds while the result register is occupied
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_OUT) && status.out_busy |=> (pc_reg == PC_OUT))
        else $error("output step left while result register busy");

endmodule

`default_nettype wire

### tb/sv/touch_baseline_step_counter_tb.sv
// Self-checking testbench for the touch baseline step counter: directed and random readings
`timescale 1ns / 1ps

module touch_baseline_step_counter_tb;

    import tbsc_pkg::*;

    // operation codes carried by the operation port
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_COUNT     = 1'b1;

    localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // cycles after the last result before the final verdict
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             cal;
        logic [SMP_W-1:0] base;
        logic [SMP_W-1:0] thresh;
    } status_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             operation    = OP_CALIBRATE;
    logic [SMP_W-1:0] sample       = '0;
    logic             out_stall    = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [CNT_W-1:0] person_count;
    logic             calibrated;
    logic [SMP_W-1:0] baseline;
    logic [SMP_W-1:0] noise_threshold;

    // expected status words, oldest first
    status_t pending_status[$];
    int      error_count = 0;
    int      cycle_count = 0;

    // stall control shared with the receiver process
    bit idle_on  = 1'b0;
    int hold_len = 0;
    int hold_req = 0;

    // shadow of the block state
    logic [CNT_W-1:0] people;
    logic [SMP_W-1:0] prev_reading;
    bit               prev_ok;
    logic [SMP_W-1:0] base_level;
    logic [SMP_W-1:0] noise_level;
    bit               cal_seen;
    longint unsigned  win_sum;
    longint unsigned  win_sq;
    int               win_fill;
    int               windows_done;

    touch_baseline_step_counter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .person_count    (person_count),
        .calibrated      (calibrated),
        .baseline        (baseline),
        .noise_threshold (noise_threshold)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SMP_W-1:0] clamp_reading(int v);
        if (v < 0)
            return '0;
        else if (v > int'(SMP_MAX))
            return SMP_MAX;
        else
            return v[SMP_W-1:0];
    endfunction

    // floor of the square root, built bit by bit from the top
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    task automatic clear_shadow();
        people       = '0;
        prev_reading = '0;
        prev_ok      = 1'b0;
        base_level   = SMP_MAX;
        noise_level  = '0;
        cal_seen     = 1'b0;
        win_sum      = 0;
        win_sq       = 0;
        win_fill     = 0;
        windows_done = 0;
    endtask

    // close a calibration window: rounded mean and ceil(1.5 sigma), from a Q.4 sigma
    task automatic close_window();
        longint unsigned n;
        longint unsigned sq;
        longint unsigned nq;
        longint unsigned d;
        longint unsigned mean;
        longint unsigned sig;
        longint unsigned th;
        n    = CAL_SAMPLES;
        sq   = win_sum * win_sum;
        nq   = n * win_sq;
        d    = (nq > sq) ? nq - sq : 0;
        mean = (2 * win_sum + n) / (2 * n);
        sig  = root_floor((d * 256) / (n * n));
        th   = (3 * sig + 31) / 32;
        base_level   = (mean > SMP_MAX) ? SMP_MAX : mean[SMP_W-1:0];
        noise_level  = (th > SMP_MAX) ? SMP_MAX : th[SMP_W-1:0];
        win_sum      = 0;
        win_sq       = 0;
        win_fill     = 0;
        cal_seen     = 1'b1;
        prev_ok      = 1'b0;
        windows_done++;
    endtask

    // advance the shadow state by one accepted request and queue its status
    task automatic apply_reading(input logic op, input logic [SMP_W-1:0] smp);
        status_t st;
        int      x;
        int      th;
        x  = int'(smp);
        th = int'(noise_level);
        if (op == OP_CALIBRATE)
        begin
            win_sum += 64'(smp);
            win_sq  += 64'(smp) * 64'(smp);
            win_fill++;
            if (win_fill >= CAL_SAMPLES)
                close_window();
        end
        else if (!prev_ok)
        begin
            prev_reading = smp;
            prev_ok      = 1'b1;
        end
        else
        begin
            if (x > int'(base_level) - th)
                people = '0;
            else if (x > int'(prev_reading) + th)
            begin
                if (people != '0)
                    people--;
            end
            else if (x < int'(prev_reading) - th)
            begin
                if (people != CNT_MAX)
                    people++;
            end
            prev_reading = smp;
        end
        st.count  = people;
        st.cal    = cal_seen;
        st.base   = base_level;
        st.thresh = noise_level;
        pending_status.push_back(st);
    endtask

    // offer one request, hold it until accepted, then predict
    task automatic send_reading(input logic op, input logic [SMP_W-1:0] smp);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample    <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_reading(op, smp);
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // counting reading aimed at one of the step cases
    function automatic logic [SMP_W-1:0] pick_count_reading();
        int last;
        int th;
        int r;
        int v;
        last = int'(prev_reading);
        th   = int'(noise_level);
        r    = $urandom_range(0, 9);
        if (r < 3)
            v = last - th - int'($urandom_range(1, 500));
        else if (r < 5)
            v = last + th + int'($urandom_range(1, 500));
        else if (r < 7)
            v = last + int'($urandom_range(0, 2 * th)) - th;
        else if (r < 8)
            v = int'(base_level) - th + int'($urandom_range(0, 300));
        else
            v = int'($urandom_range(0, 65535));
        return clamp_reading(v);
    endfunction

    // send calibration requests until the current window closes,
    // with a counting request mixed in now and then
    task automatic fill_window(input int level, input int amp, input bit alternate);
        int start;
        int v;
        start = windows_done;
        while (windows_done == start)
        begin
            if ($urandom_range(0, 15) == 0)
                send_reading(OP_COUNT, pick_count_reading());
            else
            begin
                if (alternate)
                    v = (win_fill % 2) ? int'(SMP_MAX) : 0;
                else
                    v = level + int'($urandom_range(0, 2 * amp)) - amp;
                send_reading(OP_CALIBRATE, clamp_reading(v));
            end
        end
    endtask

    // first counting reading only stores, then single-step changes both ways
    task automatic test_uncalibrated_steps();
        idle_on = 1'b1;
        send_reading(OP_COUNT, SMP_MAX);
        send_reading(OP_COUNT, SMP_MAX);
        send_reading(OP_COUNT, SMP_MAX - 1);
        send_reading(OP_COUNT, 16'h0000);
        send_reading(OP_COUNT, SMP_MAX);
        send_reading(OP_COUNT, 16'h0000);
        send_reading(OP_COUNT, 16'h0001);
        send_reading(OP_COUNT, 16'h0002);
        send_reading(OP_COUNT, 16'h0003);
        send_reading(OP_COUNT, 16'h5555);
        send_reading(OP_COUNT, 16'hAAAA);
        send_reading(OP_COUNT, 16'h5555);
    endtask

    // long run of drops drives the count into its upper limit
    task automatic test_count_saturation();
        int i;
        idle_on = 1'b0;
        for (i = 0; i < 270; i++)
            send_reading(OP_COUNT, 16'(60000 - 200 * i));
    endtask

    // widest spread: threshold above the baseline, so every count clears
    task automatic test_spread_window();
        idle_on = 1'b1;
        send_reading(OP_COUNT, 16'h4000);
        send_reading(OP_COUNT, 16'h2000);
        fill_window(0, 0, 1'b1);
        send_reading(OP_COUNT, 16'h0000);
        send_reading(OP_COUNT, 16'h0000);
        send_reading(OP_COUNT, SMP_MAX);
        send_reading(OP_COUNT, 16'h0000);
    endtask

    // receiver holds off while requests keep coming, then the sender waits for all results
    task automatic test_backpressure();
        int i;
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        hold_req++;
        for (i = 0; i < 24; i++)
            send_reading(OP_COUNT, pick_count_reading());
        wait_drained();
    endtask

    // random counting runs with stray calibration requests
    task automatic test_random_traffic();
        int round;
        int i;
        for (round = 0; round < 3; round++)
        begin
            idle_on = (round != 1);
            if (round == 2)
                wait_drained();
            for (i = 0; i < 20; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_reading(OP_CALIBRATE, 16'($urandom_range(0, 65535)));
                else
                    send_reading(OP_COUNT, pick_count_reading());
            end
        end
    endtask

    // receiver stall pattern: long hold on request, else random bursts when idle_on is set
    always @(negedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        int stall_left;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0 && idle_on)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // compare each delivered status with the oldest prediction
    always @(posedge clk)
    begin : status_check
        status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual count %0d",
                         $time, person_count);
                error_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                report_field("person_count", want.count, person_count);
                report_field("calibrated", want.cal, calibrated);
                report_field("baseline", want.base, baseline);
                report_field("noise_threshold", want.thresh, noise_threshold);
            end
        end
    end

    initial
    begin
        clear_shadow();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_uncalibrated_steps();
        test_count_saturation();
        test_spread_window();
        test_backpressure();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        idle_on = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
